>>> src/hdlc_dfr_pkg.sv
// Shared types and constants of the HDLC octet deframer.
// No dependencies; every other file imports this package.
package hdlc_dfr_pkg;

  // Size of one frame buffer in octets
  localparam int unsigned BufferBytes = 256;

  // Hard cap on the frame size limit: the buffer size, at most 256 octets
  localparam int unsigned BufCapInt = (BufferBytes > 256) ? 256 : BufferBytes;
  localparam logic [8:0]  BufCap    = 9'(BufCapInt);

  // A format-field octet with this bit set is malformed
  localparam logic [7:0] FormatBadBit = 8'h80;

  // Register file geometry
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    CMD_OCTET    = 2'd0,
    CMD_LINE_ERR = 2'd1,
    CMD_TIMEOUT  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_LINE_ERR = 3'd1,
    CAUSE_TOO_LONG = 3'd2,
    CAUSE_FORMAT   = 3'd3,
    CAUSE_TIMEOUT  = 3'd4
  } cause_e;

  typedef enum logic [2:0] {
    REG_FLAG_OCTET    = 3'd0,
    REG_MIN_LENGTH    = 3'd1,
    REG_MAX_FRAME     = 3'd2,
    REG_HAS_FORMAT    = 3'd3,
    REG_TRANSPARENCY  = 3'd4
  } reg_idx_e;

  // Current configuration seen by the frame engine
  typedef struct packed {
    logic [7:0] flag_octet;
    logic [7:0] min_length;
    logic [8:0] max_frame_size;
    logic       has_format_field;
    logic       transparency_on;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_index;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       frame_dropped;
    logic [2:0] drop_cause;
    logic       frame_opened;
    logic       short_restart;
  } result_t;

endpackage

>>> src/hdlc_dfr_cfg.sv
// APB-style configuration registers of the HDLC octet deframer.
// Depends on hdlc_dfr_pkg for the register indexes and the cfg_t struct.
module hdlc_dfr_cfg
  import hdlc_dfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_octet       <= 8'h7E;
      cfg_q.min_length       <= 8'd4;
      cfg_q.max_frame_size   <= 9'd256;
      cfg_q.has_format_field <= 1'b0;
      cfg_q.transparency_on  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FLAG_OCTET:   cfg_q.flag_octet       <= pwdata[7:0];
        REG_MIN_LENGTH:   cfg_q.min_length       <= pwdata[7:0];
        REG_MAX_FRAME:    cfg_q.max_frame_size   <= pwdata[8:0];
        REG_HAS_FORMAT:   cfg_q.has_format_field <= pwdata[0];
        REG_TRANSPARENCY: cfg_q.transparency_on  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_FLAG_OCTET:   prdata = {24'd0, cfg_q.flag_octet};
      REG_MIN_LENGTH:   prdata = {24'd0, cfg_q.min_length};
      REG_MAX_FRAME:    prdata = {23'd0, cfg_q.max_frame_size};
      REG_HAS_FORMAT:   prdata = {31'd0, cfg_q.has_format_field};
      REG_TRANSPARENCY: prdata = {31'd0, cfg_q.transparency_on};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/hdlc_dfr_core.sv
// Frame engine of the HDLC octet deframer: hunt/frame state and the
// single-pass step logic for one beat. Depends on hdlc_dfr_pkg.
module hdlc_dfr_core
  import hdlc_dfr_pkg::*;
#(
  parameter int unsigned BufBytes = BufferBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  cfg_t       cfg_i,
  input  logic [1:0] cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       buffer_free_i,
  output result_t    result_o
);

  // Hard cap on the frame size limit: the buffer size, at most 256 octets
  localparam int unsigned CapInt = (BufBytes > 256) ? 256 : BufBytes;
  localparam logic [8:0]  Cap    = 9'(CapInt);

  logic       in_frame_q, in_frame_d;
  logic [7:0] frame_len_q, frame_len_d;
  logic [7:0] write_pos_q, write_pos_d;
  logic [6:0] count_left_q, count_left_d;
  logic       error_latch_q, error_latch_d;

  logic       claim;
  logic       checked;
  logic       is_flag;
  logic       fmt_mode;
  logic [8:0] lim;
  logic [8:0] next_len;
  result_t    res;

  // Effective size limit
  assign lim      = (cfg_i.max_frame_size > Cap) ? Cap : cfg_i.max_frame_size;
  assign is_flag  = (data_byte_i == cfg_i.flag_octet);
  assign fmt_mode = cfg_i.has_format_field & ~cfg_i.transparency_on;
  assign next_len = {1'b0, frame_len_q} + 9'd1;

  // Step logic for one accepted beat
  always_comb begin
    in_frame_d    = in_frame_q;
    frame_len_d   = frame_len_q;
    write_pos_d   = write_pos_q;
    count_left_d  = count_left_q;
    error_latch_d = error_latch_q;
    res           = '0;
    claim         = 1'b0;
    checked       = 1'b1;
    if (step_i) begin
      case (cmd_i)
        CMD_LINE_ERR: error_latch_d = 1'b1;
        CMD_TIMEOUT: begin
          if (in_frame_q) begin
            res.frame_dropped = 1'b1;
            res.drop_cause    = CAUSE_TIMEOUT;
            in_frame_d        = 1'b0;
            frame_len_d       = '0;
            write_pos_d       = '0;
            count_left_d      = '0;
            error_latch_d     = 1'b0;
          end
        end
        CMD_OCTET: begin
          if (!in_frame_q) begin
            claim = is_flag;
          end else begin
            res.write_enable = 1'b1;
            res.write_index  = write_pos_q;
            // Count in octets announced by the format field
            if (count_left_q != '0) begin
              count_left_d = count_left_q - 7'd1;
              if (count_left_q != 7'd1) begin
                write_pos_d = write_pos_q + 8'd1;
                checked     = 1'b0;
              end
            end
            if (checked) begin
              if (is_flag) begin
                if (frame_len_q == '0) begin
                  // empty frame: keep waiting
                end else if (frame_len_q < cfg_i.min_length) begin
                  frame_len_d       = '0;
                  write_pos_d       = '0;
                  res.short_restart = 1'b1;
                end else begin
                  res.frame_done   = 1'b1;
                  res.frame_length = frame_len_q;
                  in_frame_d       = 1'b0;
                  frame_len_d      = '0;
                  write_pos_d      = '0;
                  count_left_d     = '0;
                  claim            = 1'b1;
                end
              end else if (error_latch_q) begin
                res.frame_dropped = 1'b1;
                res.drop_cause    = CAUSE_LINE_ERR;
                in_frame_d        = 1'b0;
                frame_len_d       = '0;
                write_pos_d       = '0;
                count_left_d      = '0;
              end else if (frame_len_q == '0 && fmt_mode) begin
                if ((data_byte_i & FormatBadBit) != '0 || data_byte_i == '0 ||
                    {1'b0, data_byte_i} >= lim) begin
                  res.frame_dropped = 1'b1;
                  res.drop_cause    = CAUSE_FORMAT;
                  in_frame_d        = 1'b0;
                  frame_len_d       = '0;
                  write_pos_d       = '0;
                  count_left_d      = '0;
                end else begin
                  frame_len_d  = data_byte_i;
                  write_pos_d  = 8'd1;
                  count_left_d = data_byte_i[6:0];
                end
              end else if (next_len >= lim) begin
                res.frame_dropped = 1'b1;
                res.drop_cause    = CAUSE_TOO_LONG;
                in_frame_d        = 1'b0;
                frame_len_d       = '0;
                write_pos_d       = '0;
                count_left_d      = '0;
              end else begin
                frame_len_d = next_len[7:0];
                write_pos_d = next_len[7:0];
              end
            end
          end
          // Claim a buffer for the next frame
          if (claim && buffer_free_i) begin
            in_frame_d       = 1'b1;
            frame_len_d      = '0;
            write_pos_d      = '0;
            count_left_d     = '0;
            res.frame_opened = 1'b1;
          end
          if (checked) begin
            error_latch_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold frame state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      frame_len_q   <= '0;
      write_pos_q   <= '0;
      count_left_q  <= '0;
      error_latch_q <= 1'b0;
    end else begin
      in_frame_q    <= in_frame_d;
      frame_len_q   <= frame_len_d;
      write_pos_q   <= write_pos_d;
      count_left_q  <= count_left_d;
      error_latch_q <= error_latch_d;
    end
  end

  assign result_o = res;

  // While hunting, all frame counters sit at zero
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (frame_len_q == '0 && write_pos_q == '0 && count_left_q == '0))
    else $error("frame counters not cleared while hunting");

  // A counted run always belongs to a frame with a nonzero length
  a_count_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_left_q != '0 |-> frame_len_q != '0)
    else $error("counted octets pending with zero frame length");

  // Delivery excludes drop and restart in the same beat
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.frame_done |-> (!res.frame_dropped && !res.short_restart))
    else $error("frame delivered and dropped or restarted at once");

  // After a drop the engine hunts
  a_drop_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.frame_dropped |=> !in_frame_q)
    else $error("still in frame after a drop");

endmodule

>>> src/hdlc_dfr_outreg.sv
// Result register of the HDLC octet deframer: holds one result beat
// until the receiver takes it. Depends on hdlc_dfr_pkg for result_t.
module hdlc_dfr_outreg
  import hdlc_dfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  // Free when empty or being drained this cycle
  assign free_o = ~valid_q | out_ready_i;

  // Track occupancy of the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

>>> src/hdlc_octet_deframer.sv
// HDLC octet deframer, receive side of an octet-synchronous HDLC link.
// Input beat: cmd_i (0 octet, 1 line error, 2 idle timeout), data_byte_i,
// buffer_free_i, on a valid/ready channel. Every input beat yields exactly
// one result beat on the output valid/ready channel: buffer write strobe and
// index, frame delivered with its length, frame dropped with its cause,
// buffer claimed for the next frame, and too-short restart.
// The result of a beat is presented in the cycle after acceptance. Throughput:
// one beat per cycle unless stalled; the step is a single pass of compares and
// counter updates between the frame state registers and the result register.
// Stall: the result register holds a beat until out_ready_i; in_ready_o stays
// high while that register is empty or drains in the same cycle, so a beat
// can enter while the previous result is taken.
// Reset (rst_ni low): the engine hunts for a flag, counters and error latch
// clear, the output is empty, and registers return to their defaults
// (flag 0x7E, minimum length 4, maximum frame size 256, format field off).
// Configuration: APB-style port, register i at byte address 4*i; write only
// while no beat is in flight.
module hdlc_octet_deframer
  import hdlc_dfr_pkg::*;
#(
  parameter int unsigned BufBytes = BufferBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 buffer_free_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 write_enable_o,
  output logic [7:0]           write_index_o,
  output logic                 frame_done_o,
  output logic [7:0]           frame_length_o,
  output logic                 frame_dropped_o,
  output logic [2:0]           drop_cause_o,
  output logic                 frame_opened_o,
  output logic                 short_restart_o
);

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    out_free;
  logic    step;

  assign in_ready_o = out_free;
  assign step       = in_valid_i & out_free;

  // Configuration registers
  hdlc_dfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Frame engine
  hdlc_dfr_core #(
    .BufBytes (BufBytes)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .cfg_i         (cfg),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .buffer_free_i (buffer_free_i),
    .result_o      (step_res)
  );

  // Result register
  hdlc_dfr_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .result_o    (out_res)
  );

  assign write_enable_o  = out_res.write_enable;
  assign write_index_o   = out_res.write_index;
  assign frame_done_o    = out_res.frame_done;
  assign frame_length_o  = out_res.frame_length;
  assign frame_dropped_o = out_res.frame_dropped;
  assign drop_cause_o    = out_res.drop_cause;
  assign frame_opened_o  = out_res.frame_opened;
  assign short_restart_o = out_res.short_restart;

endmodule

>>> bench/hdlc_octet_deframer_test.sv
// Self-checking bench for the HDLC octet deframer: queued octet, error and
// timeout beats against a local frame predictor, under several register settings.
// Depends on hdlc_dfr_pkg and hdlc_octet_deframer from the RTL tree.
`timescale 1ns / 1ps

module hdlc_octet_deframer_test;
  import hdlc_dfr_pkg::*;

  localparam int StallLimit    = 4000;
  localparam int HoldoffCycles = 200;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
    logic       bfree;
  } octet_beat_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel, penable, pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata, prdata;
  logic                 pready;
  logic                 in_valid_i, in_ready_o;
  logic [1:0]           cmd_i;
  logic [7:0]           data_byte_i;
  logic                 buffer_free_i;
  logic                 out_valid_o, out_ready_i;
  logic                 write_enable_o, frame_done_o, frame_dropped_o;
  logic                 frame_opened_o, short_restart_o;
  logic [7:0]           write_index_o, frame_length_o;
  logic [2:0]           drop_cause_o;

  // Beats waiting to be offered, and results owed by the block
  octet_beat_t octet_backlog[$];
  result_t     awaited_results[$];

  // Predictor copy of the registers and of the framing state
  logic [7:0] cf_flag, cf_min;
  logic [8:0] cf_max;
  logic       cf_fmt, cf_transp;
  logic       pr_in_frame, pr_err;
  logic [7:0] pr_len, pr_pos;
  logic [6:0] pr_count;

  int   send_gap_pct, stall_pct;
  logic want_holdoff;
  int   holdoff_left;
  int   mismatch_count;
  int   results_seen;

  hdlc_octet_deframer uut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .data_byte_i, .buffer_free_i,
    .out_valid_o, .out_ready_i,
    .write_enable_o, .write_index_o, .frame_done_o, .frame_length_o,
    .frame_dropped_o, .drop_cause_o, .frame_opened_o, .short_restart_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [8:0] size_limit();
    return (cf_max > BufCap) ? BufCap : cf_max;
  endfunction

  function automatic void back_to_hunt();
    pr_in_frame = 1'b0;
    pr_len      = '0;
    pr_pos      = '0;
    pr_count    = '0;
  endfunction

  // Advance the framing state by one beat and return the result it owes
  function automatic result_t deframe_octet(cmd_e cmd, logic [7:0] b, logic bf);
    result_t    r;
    logic [8:0] lim;
    logic [8:0] nl;
    logic       claim;
    logic       checked;
    r       = '0;
    lim     = size_limit();
    claim   = 1'b0;
    checked = 1'b1;
    case (cmd)
      CMD_LINE_ERR: pr_err = 1'b1;
      CMD_TIMEOUT: begin
        if (pr_in_frame) begin
          r.frame_dropped = 1'b1;
          r.drop_cause    = CAUSE_TIMEOUT;
          back_to_hunt();
          pr_err = 1'b0;
        end
      end
      CMD_OCTET: begin
        if (!pr_in_frame) begin
          claim = (b == cf_flag);
        end else begin
          r.write_enable = 1'b1;
          r.write_index  = pr_pos;
          // counted octets skip every check until the last one
          if (pr_count != 0) begin
            pr_count--;
            if (pr_count != 0) begin
              pr_pos++;
              checked = 1'b0;
            end
          end
          if (checked) begin
            if (b == cf_flag) begin
              if (pr_len == 0) begin
                // empty frame: keep waiting
              end else if (pr_len < cf_min) begin
                pr_len          = '0;
                pr_pos          = '0;
                r.short_restart = 1'b1;
              end else begin
                r.frame_done   = 1'b1;
                r.frame_length = pr_len;
                back_to_hunt();
                claim = 1'b1;
              end
            end else if (pr_err) begin
              r.frame_dropped = 1'b1;
              r.drop_cause    = CAUSE_LINE_ERR;
              back_to_hunt();
            end else if (pr_len == 0 && cf_fmt && !cf_transp) begin
              if ((b & FormatBadBit) != 0 || b == 0 || {1'b0, b} >= lim) begin
                r.frame_dropped = 1'b1;
                r.drop_cause    = CAUSE_FORMAT;
                back_to_hunt();
              end else begin
                pr_len   = b;
                pr_pos   = 8'd1;
                pr_count = b[6:0];
              end
            end else begin
              nl = {1'b0, pr_len} + 9'd1;
              if (nl >= lim) begin
                r.frame_dropped = 1'b1;
                r.drop_cause    = CAUSE_TOO_LONG;
                back_to_hunt();
              end else begin
                pr_len = nl[7:0];
                pr_pos = nl[7:0];
              end
            end
          end
        end
        // claim a buffer for the next frame
        if (claim && bf) begin
          pr_in_frame    = 1'b1;
          pr_len         = '0;
          pr_pos         = '0;
          pr_count       = '0;
          r.frame_opened = 1'b1;
        end
        if (checked) pr_err = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string field, int got, int want);
    mismatch_count++;
    $display("[%0t] result %0d: %s is %0d, expected %0d",
             $realtime, results_seen, field, got, want);
  endtask

  // Offer queued beats; hold the current one until the block takes it
  always @(posedge clk_i) begin : feed_octets
    octet_beat_t nxt;
    logic        hold;
    hold = in_valid_i && !in_ready_o;
    if (in_valid_i && in_ready_o) begin
      awaited_results.push_back(deframe_octet(cmd_e'(cmd_i), data_byte_i, buffer_free_i));
    end
    if (!hold) begin
      if (rst_ni && octet_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = octet_backlog.pop_front();
        in_valid_i    <= 1'b1;
        cmd_i         <= nxt.cmd;
        data_byte_i   <= nxt.data;
        buffer_free_i <= nxt.bfree;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Pace the receiver: random stalls, or one long hold-off on request
  always @(posedge clk_i) begin : pace_receiver
    if (want_holdoff) begin
      holdoff_left = HoldoffCycles;
      want_holdoff = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {write_enable_o, write_index_o, frame_done_o, frame_length_o,
             frame_dropped_o, drop_cause_o, frame_opened_o, short_restart_o};
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected beat", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (got.write_enable !== want.write_enable)
          note_mismatch("write_enable", got.write_enable, want.write_enable);
        if (got.write_index !== want.write_index)
          note_mismatch("write_index", got.write_index, want.write_index);
        if (got.frame_done !== want.frame_done)
          note_mismatch("frame_done", got.frame_done, want.frame_done);
        if (got.frame_length !== want.frame_length)
          note_mismatch("frame_length", got.frame_length, want.frame_length);
        if (got.frame_dropped !== want.frame_dropped)
          note_mismatch("frame_dropped", got.frame_dropped, want.frame_dropped);
        if (got.drop_cause !== want.drop_cause)
          note_mismatch("drop_cause", got.drop_cause, want.drop_cause);
        if (got.frame_opened !== want.frame_opened)
          note_mismatch("frame_opened", got.frame_opened, want.frame_opened);
        if (got.short_restart !== want.short_restart)
          note_mismatch("short_restart", got.short_restart, want.short_restart);
      end
      results_seen++;
    end
  end

  // End the run when no beat moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void set_idling(idling_e mode);
    send_gap_pct = (mode == IDLE_SENDER) ? 60 : (mode == IDLE_BOTH) ? 20 : 0;
    stall_pct    = (mode == IDLE_RECEIVER) ? 60 : (mode == IDLE_BOTH) ? 20 : 0;
  endfunction

  function automatic void enqueue(cmd_e c, logic [7:0] d, logic bf);
    octet_beat_t beat;
    beat.cmd   = c;
    beat.data  = d;
    beat.bfree = bf;
    octet_backlog.push_back(beat);
  endfunction

  function automatic logic [7:0] any_but_flag();
    logic [7:0] b;
    do b = 8'($urandom); while (b == cf_flag);
    return b;
  endfunction

  function automatic logic likely_free();
    return $urandom_range(9) != 0;
  endfunction

  // Plain frame body followed by the closing flag, which also opens the next
  function automatic void queue_plain_frame();
    int lim;
    int len;
    lim = size_limit();
    case ($urandom_range(9))
      0:       len = $urandom_range(lim + 1);
      1, 2:    len = cf_min + $urandom_range(3);
      default: len = $urandom_range(6);
    endcase
    repeat (len) enqueue(CMD_OCTET, any_but_flag(), 1'($urandom));
    enqueue(CMD_OCTET, cf_flag, likely_free());
  endfunction

  // Length octet, the counted octets (any value, flag too), then the flag
  function automatic void queue_format_frame();
    int         lim;
    int         hi;
    logic [7:0] len;
    lim = size_limit();
    hi  = (lim - 1 > 12) ? 12 : lim - 1;
    if (hi < 1 || $urandom_range(5) == 0) begin
      case ($urandom_range(2))
        0:       len = 8'h00;
        1:       len = FormatBadBit | 8'($urandom);
        default: len = (lim > 127) ? 8'($urandom_range(lim, 255))
                                   : 8'($urandom_range(lim, 127));
      endcase
    end else begin
      len = 8'($urandom_range(hi, 1));
    end
    enqueue(CMD_OCTET, len, 1'($urandom));
    if (len != 0 && len < 8'h80) begin
      repeat (int'(len) - 1) enqueue(CMD_OCTET, 8'($urandom), 1'($urandom));
    end
    enqueue(CMD_OCTET, cf_flag, likely_free());
  endfunction

  function automatic void queue_noise();
    case ($urandom_range(6))
      0: enqueue(CMD_LINE_ERR, 8'($urandom), 1'($urandom));
      1: enqueue(CMD_TIMEOUT, 8'($urandom), 1'($urandom));
      2: enqueue(CMD_UNUSED, 8'($urandom), 1'($urandom));
      3: enqueue(CMD_OCTET, 8'($urandom), 1'($urandom));
      4: enqueue(CMD_OCTET, cf_flag, 1'b0);
      5: enqueue(CMD_OCTET, cf_flag, 1'b1);
      default: begin
        enqueue(CMD_LINE_ERR, 8'($urandom), 1'($urandom));
        enqueue(CMD_OCTET, 8'($urandom), 1'($urandom));
      end
    endcase
  endfunction

  function automatic void build_traffic(int n_beats);
    int target;
    target = octet_backlog.size() + n_beats;
    while (octet_backlog.size() < target) begin
      if ($urandom_range(99) < 70) begin
        if (cf_fmt && !cf_transp) queue_format_frame();
        else queue_plain_frame();
      end else begin
        queue_noise();
      end
    end
  endfunction

  // Hunting corner cases, empty and short frames, latch, delivery, timeout
  function automatic void queue_directed();
    enqueue(CMD_TIMEOUT, 8'h00, 1'b1);
    enqueue(CMD_LINE_ERR, 8'hFF, 1'b0);
    enqueue(CMD_UNUSED, 8'hA5, 1'b1);
    enqueue(CMD_OCTET, 8'h00, 1'b1);
    enqueue(CMD_OCTET, cf_flag, 1'b0);
    enqueue(CMD_OCTET, cf_flag, 1'b1);
    enqueue(CMD_OCTET, cf_flag, 1'b1);
    enqueue(CMD_OCTET, 8'hFF, 1'b0);
    enqueue(CMD_OCTET, 8'h00, 1'b1);
    enqueue(CMD_OCTET, cf_flag, 1'b1);
    enqueue(CMD_OCTET, 8'h55, 1'b0);
    enqueue(CMD_OCTET, 8'hAA, 1'b1);
    enqueue(CMD_OCTET, 8'h01, 1'b0);
    enqueue(CMD_OCTET, 8'hFE, 1'b1);
    enqueue(CMD_LINE_ERR, 8'h00, 1'b0);
    enqueue(CMD_OCTET, 8'h12, 1'b1);
    enqueue(CMD_OCTET, cf_flag, 1'b1);
    enqueue(CMD_LINE_ERR, 8'h00, 1'b1);
    enqueue(CMD_OCTET, cf_flag, 1'b1);
    repeat (5) enqueue(CMD_OCTET, any_but_flag(), 1'b1);
    enqueue(CMD_OCTET, cf_flag, 1'b0);
    enqueue(CMD_OCTET, cf_flag, 1'b1);
    enqueue(CMD_OCTET, 8'h80, 1'b1);
    enqueue(CMD_TIMEOUT, 8'h00, 1'b0);
  endfunction

  // Wait until every queued beat is taken and every result has come back
  task automatic settle();
    do @(negedge clk_i);
    while (octet_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FLAG_OCTET:   cf_flag   = val[7:0];
      REG_MIN_LENGTH:   cf_min    = val[7:0];
      REG_MAX_FRAME:    cf_max    = val[8:0];
      REG_HAS_FORMAT:   cf_fmt    = val[0];
      REG_TRANSPARENCY: cf_transp = val[0];
      default: ;
    endcase
  endtask

  // Reprogram while idle, then run two chunks with a full drain between
  task automatic run_phase(logic [7:0] flag, logic [7:0] min_len, logic [8:0] max_sz,
                           logic fmt, logic transp, idling_e mode, int n_beats,
                           logic holdoff);
    write_reg(REG_FLAG_OCTET, 32'(flag));
    write_reg(REG_MIN_LENGTH, 32'(min_len));
    write_reg(REG_MAX_FRAME, 32'(max_sz));
    write_reg(REG_HAS_FORMAT, 32'(fmt));
    write_reg(REG_TRANSPARENCY, 32'(transp));
    @(negedge clk_i);
    set_idling(mode);
    if (holdoff) want_holdoff = 1'b1;
    build_traffic(n_beats / 2);
    settle();
    build_traffic(n_beats - n_beats / 2);
    settle();
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_OCTET;
    data_byte_i   = '0;
    buffer_free_i = 1'b0;
    out_ready_i   = 1'b0;
    want_holdoff  = 1'b0;
    holdoff_left  = 0;
    mismatch_count = 0;
    results_seen  = 0;
    cf_flag   = 8'h7E;
    cf_min    = 8'd4;
    cf_max    = 9'd256;
    cf_fmt    = 1'b0;
    cf_transp = 1'b0;
    pr_err    = 1'b0;
    back_to_hunt();
    set_idling(IDLE_NONE);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats on the reset settings, then random traffic at defaults
    // (long frames overshoot each chunk, so the chunk sizes stay modest)
    queue_directed();
    settle();
    build_traffic(40);
    settle();

    run_phase(8'h00, 8'd0, 9'd2, 1'b0, 1'b0, IDLE_SENDER, 120, 1'b0);
    run_phase(8'hFF, 8'd255, 9'd256, 1'b0, 1'b0, IDLE_RECEIVER, 60, 1'b0);
    run_phase(8'h7E, 8'd1, 9'd40, 1'b1, 1'b0, IDLE_BOTH, 160, 1'b0);
    run_phase(8'h7E, 8'd2, 9'd130, 1'b1, 1'b0, IDLE_NONE, 160, 1'b1);
    run_phase(8'($urandom), 8'd3, 9'd256, 1'b1, 1'b1, IDLE_BOTH, 80, 1'b0);
    run_phase(8'h7E, 8'd4, 9'd256, 1'b0, 1'b0, IDLE_SENDER, 80, 1'b0);

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
